// File: src/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam logic [31:0] MAX_PAYLOAD_RST = 32'd4096;

	// parse phases
	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_DROP    = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_OP    = 2'd1;
	localparam logic [1:0] ST_TOO_LONG  = 2'd2;
	localparam logic [1:0] ST_TRUNCATED = 2'd3;

	localparam logic [3:0] OP_TEXT   = 4'd1;
	localparam logic [3:0] OP_BINARY = 4'd2;

	localparam logic [6:0] LEN7_MAX  = 7'd125;
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       is_status;
		logic [1:0] status;
		logic [3:0] frame_opcode;
		logic       fin_flag;
		logic       masked_flag;
		logic       last_of_frame;
	} result_t;

endpackage

// File: src/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser and payload unmasker, one byte per accepted transaction.
// ----------------------------------------------------------------------------
module wsd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	input  logic             take,
	input  logic [7:0]       data_byte,
	input  logic             end_of_buffer,
	output logic             res_valid,
	output wsd_pkg::result_t res
);
	import wsd_pkg::*;

	logic [31:0] max_payload_q;
	logic [2:0]  phase_q, phase_d;
	logic [7:0]  hdr_q, hdr_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  idx_q, idx_d;
	logic        mflag_q, mflag_d;

	logic        frame_done;
	logic [1:0]  err;
	logic        pay_res;
	logic        pay_last;
	logic [7:0]  pay_byte;
	logic [7:0]  key_byte;
	logic        too_long;
	logic [3:0]  op;
	logic [6:0]  len7;

	always_comb begin
		phase_d    = phase_q;
		hdr_d      = hdr_q;
		cnt_d      = cnt_q;
		len_d      = len_q;
		key_d      = key_q;
		idx_d      = idx_q;
		mflag_d    = mflag_q;
		frame_done = 1'b0;
		err        = ST_OK;
		pay_res    = 1'b0;
		pay_last   = 1'b0;
		pay_byte   = 8'd0;
		too_long   = 1'b0;
		op         = hdr_q[3:0];
		len7       = data_byte[6:0];
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
		case (phase_q)
			PH_HDR0: begin
				hdr_d   = data_byte;
				phase_d = PH_HDR1;
			end
			PH_HDR1: begin
				mflag_d = data_byte[7];
				if (!(op inside {OP_TEXT, OP_BINARY})) begin
					err     = ST_BAD_OP;
					phase_d = PH_DROP;
				end else if (len7 <= LEN7_MAX) begin
					len_d    = {57'd0, len7};
					too_long = (len7 > 7'(max_payload_q[6:0])) && (max_payload_q[31:7] == '0);
					if (too_long) begin
						err     = ST_TOO_LONG;
						phase_d = PH_DROP;
					end else begin
						cnt_d   = KEY_BYTES;
						phase_d = PH_KEY;
					end
				end else begin
					len_d   = '0;
					cnt_d   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
					phase_d = PH_EXTLEN;
				end
			end
			PH_EXTLEN: begin
				len_d    = {len_q[55:0], data_byte};
				cnt_d    = cnt_q - 4'd1;
				too_long = (len_d[63:32] != '0) || (len_d[31:0] > max_payload_q);
				if (cnt_d == '0) begin
					if (too_long) begin
						err     = ST_TOO_LONG;
						phase_d = PH_DROP;
					end else begin
						cnt_d   = KEY_BYTES;
						phase_d = PH_KEY;
					end
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], data_byte};
				cnt_d = cnt_q - 4'd1;
				if (cnt_d == '0) begin
					idx_d = '0;
					if (len_q == '0) begin
						// empty payload reports ok status
						frame_done = 1'b1;
						phase_d    = PH_DROP;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				// len_q counts bytes still to come
				len_d    = len_q - 64'd1;
				idx_d    = idx_q + 2'd1;
				pay_last = (len_q == 64'd1);
				pay_byte = data_byte ^ key_byte;
				pay_res  = pay_last || !end_of_buffer;
				if (pay_last) begin
					frame_done = 1'b1;
					phase_d    = PH_DROP;
				end
			end
			default: begin
				frame_done = 1'b1;
			end
		endcase
	end

	// result assembly, header fields taken after this byte's update
	always_comb begin
		res.frame_opcode  = hdr_d[3:0];
		res.fin_flag      = hdr_d[7];
		res.masked_flag   = mflag_d;
		res.payload_byte  = 8'd0;
		res.is_status     = 1'b1;
		res.status        = ST_OK;
		res.last_of_frame = 1'b1;
		res_valid         = 1'b0;
		if (err != ST_OK) begin
			res.status = err;
			res_valid  = 1'b1;
		end else if (end_of_buffer && !frame_done) begin
			res.status = ST_TRUNCATED;
			res_valid  = 1'b1;
		end else if (phase_q == PH_KEY && frame_done) begin
			res_valid = 1'b1;
		end else if (pay_res) begin
			res.payload_byte  = pay_byte;
			res.is_status     = 1'b0;
			res.last_of_frame = pay_last;
			res_valid         = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			hdr_q   <= '0;
			cnt_q   <= '0;
			len_q   <= '0;
			key_q   <= '0;
			idx_q   <= '0;
			mflag_q <= 1'b0;
		end else if (take) begin
			if (end_of_buffer) begin
				phase_q <= PH_HDR0;
				hdr_q   <= '0;
				cnt_q   <= '0;
				len_q   <= '0;
				key_q   <= '0;
				idx_q   <= '0;
				mflag_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				hdr_q   <= hdr_d;
				cnt_q   <= cnt_d;
				len_q   <= len_d;
				key_q   <= key_d;
				idx_q   <= idx_d;
				mflag_q <= mflag_d;
			end
		end
	end

endmodule

// File: src/wsd_out_reg.sv
// ----------------------------------------------------------------------------
// wsd_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module wsd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic             res_valid,
	input  wsd_pkg::result_t res,
	input  logic             result_stall,
	output logic             busy,
	output logic             result_valid,
	output wsd_pkg::result_t result_q
);
	import wsd_pkg::*;

	logic valid_q;

	// upstream waits only while a held result is stalled
	assign busy         = valid_q && result_stall;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take && res_valid) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			result_q <= res;
		end
	end

endmodule

// File: src/websocket_frame_deframer.sv
// a result is registered and appears in the cycle after its byte is accepted
// throughput: one byte per cycle while not stalled; parser state is registered
// input stalls only while a finished result is held by a stalled consumer
// reset: asynchronous, parser returns to the header phase, max_payload to 4096
// end of buffer returns the parser to the header phase for the next frame
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses websocket frame headers byte by byte and emits unmasked payload.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  payload_byte,
	output logic        is_status,
	output logic [1:0]  status,
	output logic [3:0]  frame_opcode,
	output logic        fin_flag,
	output logic        masked_flag,
	output logic        last_of_frame
);
	import wsd_pkg::*;

	logic    take;
	logic    res_valid;
	logic    busy;
	result_t res;
	result_t result_q;

	assign data_stall = busy;
	assign take       = data_valid && !busy;

	wsd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.take          (take),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.res_valid     (res_valid),
		.res           (res)
	);

	wsd_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.res_valid    (res_valid),
		.res          (res),
		.result_stall (result_stall),
		.busy         (busy),
		.result_valid (result_valid),
		.result_q     (result_q)
	);

	assign payload_byte  = result_q.payload_byte;
	assign is_status     = result_q.is_status;
	assign status        = result_q.status;
	assign frame_opcode  = result_q.frame_opcode;
	assign fin_flag      = result_q.fin_flag;
	assign masked_flag   = result_q.masked_flag;
	assign last_of_frame = result_q.last_of_frame;

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_status |-> last_of_frame)
		else $error("status result without last_of_frame");

	a_status_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_status |-> payload_byte == 8'd0)
		else $error("status result carries payload data");

	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_status |-> status == ST_OK)
		else $error("payload result carries error status");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> result_valid && result_stall)
		else $error("input stalled without a held result");

endmodule
